// ===== sv/prime_sieve_wheel30_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wheel-30 prime sieve unit
// Concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIME_SIEVE_WHEEL30_UNIT_MACROS_SVH
`define PRIME_SIEVE_WHEEL30_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define PSW30_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a condition never occurs outside reset.
`define PSW30_ASSERT_NEVER(label, expr, msg) \
    `PSW30_ASSERT(label, !(expr), msg)
`else
`define PSW30_ASSERT(label, prop, msg)
`define PSW30_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== sv/psw30_pkg.sv =====
// ----------------------------------------------------------------------------
// psw30_pkg
// Constants, datapath commands, status bundle and wheel-30 tables.
// ----------------------------------------------------------------------------
`default_nettype none

package psw30_pkg;

    localparam int MAX_ROWS = 4096;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int CNT_W    = ROW_AW + 1;
    localparam int NROW_W   = CNT_W + 1;
    localparam int LIMIT_W  = 17;
    localparam int PRIME_W  = 17;
    localparam int TDATA_W  = 24;
    localparam int K_W      = 4;
    localparam int RES_W    = 5;

    // Reciprocal of 30 for a 17-bit dividend: floor(x * 139811 / 2^22).
    localparam int DIV30_MUL   = 139811;
    localparam int DIV30_SHIFT = 22;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_DIV,
        OP_FILL,
        OP_KCHK,
        OP_LRD,
        OP_LCHK,
        OP_STEST,
        OP_SWR,
        OP_READ,
        OP_SEEKRD,
        OP_SEEKCHK,
        OP_EMIT
    } dp_op_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
        logic k_done;
        logic lane_bit;
        logic lane_last;
        logic strike_end;
        logic run_empty;
        logic small_lt3;
        logic small_is2;
        logic at_end;
        logic found;
        logic out_free;
    } dp_status_t;

    // Residue of each lane.
    function automatic logic [RES_W-1:0] lane_res(input logic [2:0] lane);
        logic [RES_W-1:0] r;
        unique case (lane)
            3'd0: r = 5'd1;
            3'd1: r = 5'd7;
            3'd2: r = 5'd11;
            3'd3: r = 5'd13;
            3'd4: r = 5'd17;
            3'd5: r = 5'd19;
            3'd6: r = 5'd23;
            3'd7: r = 5'd29;
        endcase
        return r;
    endfunction

    // Gap from a lane's residue to the next one.
    function automatic logic [2:0] lane_gap(input logic [2:0] lane);
        logic [2:0] g;
        unique case (lane)
            3'd0: g = 3'd6;
            3'd1: g = 3'd4;
            3'd2: g = 3'd2;
            3'd3: g = 3'd4;
            3'd4: g = 3'd2;
            3'd5: g = 3'd4;
            3'd6: g = 3'd6;
            3'd7: g = 3'd2;
        endcase
        return g;
    endfunction

    // Lane of a residue; 8 marks a residue that shares a factor with 30.
    function automatic logic [3:0] res_lane(input logic [RES_W-1:0] res);
        logic [3:0] l;
        case (res)
            5'd1:    l = 4'd0;
            5'd7:    l = 4'd1;
            5'd11:   l = 4'd2;
            5'd13:   l = 4'd3;
            5'd17:   l = 4'd4;
            5'd19:   l = 4'd5;
            5'd23:   l = 4'd6;
            5'd29:   l = 4'd7;
            default: l = 4'd8;
        endcase
        return l;
    endfunction

    // Row part of the square of a lane's residue.
    function automatic logic [RES_W-1:0] sq_div(input logic [2:0] lane);
        logic [RES_W-1:0] d;
        unique case (lane)
            3'd0: d = 5'd0;
            3'd1: d = 5'd1;
            3'd2: d = 5'd4;
            3'd3: d = 5'd5;
            3'd4: d = 5'd9;
            3'd5: d = 5'd12;
            3'd6: d = 5'd17;
            3'd7: d = 5'd28;
        endcase
        return d;
    endfunction

    // Residue part of the square of a lane's residue.
    function automatic logic [RES_W-1:0] sq_mod(input logic [2:0] lane);
        logic [RES_W-1:0] m;
        unique case (lane)
            3'd0, 3'd2, 3'd5, 3'd7: m = 5'd1;
            3'd1, 3'd3, 3'd4, 3'd6: m = 5'd19;
        endcase
        return m;
    endfunction

    // Row part of residue times gap, by reciprocal: floor(x * 1093 / 2^15).
    function automatic logic [2:0] prod_div(input logic [2:0] lane, input logic [2:0] gl);
        logic [7:0]  pr;
        logic [17:0] scaled;
        pr     = 8'(lane_res(lane)) * 8'(lane_gap(gl));
        scaled = 18'(pr) * 18'd1093;
        return scaled[17:15];
    endfunction

    // Residue part of residue times gap.
    function automatic logic [RES_W-1:0] prod_mod(input logic [2:0] lane,
                                                  input logic [2:0] gl);
        logic [7:0] pr;
        pr = 8'(lane_res(lane)) * 8'(lane_gap(gl));
        return RES_W'(pr - 8'(prod_div(lane, gl)) * 8'd30);
    endfunction

endpackage

`default_nettype wire

// ===== sv/psw30_ram.sv =====
// ----------------------------------------------------------------------------
// psw30_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psw30_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/psw30_ctrl.sv =====
// ----------------------------------------------------------------------------
// psw30_ctrl
// Controller: sequences fill, marking pass, reads, seeks and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module psw30_ctrl
    import psw30_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_accept,
    input  wire logic       in_read,
    input  wire dp_status_t st,
    output dp_op_t          op,
    output logic            idle
);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_DIV     = 12'b0000_0000_0010,
        ST_FILL    = 12'b0000_0000_0100,
        ST_KCHK    = 12'b0000_0000_1000,
        ST_LRD     = 12'b0000_0001_0000,
        ST_LCHK    = 12'b0000_0010_0000,
        ST_STEST   = 12'b0000_0100_0000,
        ST_SWR     = 12'b0000_1000_0000,
        ST_READ    = 12'b0001_0000_0000,
        ST_SEEKRD  = 12'b0010_0000_0000,
        ST_SEEKCHK = 12'b0100_0000_0000,
        ST_EMIT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath command.
    always_comb
    begin
        op         = OP_NONE;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    op         = OP_CAPTURE;
                    state_next = in_read ? ST_READ : ST_DIV;
                end
            end
            ST_DIV:
            begin
                op         = OP_DIV;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                op = OP_FILL;
                if (st.fill_last)
                begin
                    state_next = ST_KCHK;
                end
            end
            ST_KCHK:
            begin
                op         = OP_KCHK;
                state_next = st.k_done ? ST_IDLE : ST_LRD;
            end
            ST_LRD:
            begin
                op         = OP_LRD;
                state_next = ST_LCHK;
            end
            ST_LCHK:
            begin
                op = OP_LCHK;
                if (st.lane_bit)
                begin
                    state_next = ST_STEST;
                end
                else
                begin
                    state_next = st.lane_last ? ST_KCHK : ST_LRD;
                end
            end
            ST_STEST:
            begin
                op = OP_STEST;
                if (st.strike_end)
                begin
                    state_next = st.lane_last ? ST_KCHK : ST_LRD;
                end
                else
                begin
                    state_next = ST_SWR;
                end
            end
            ST_SWR:
            begin
                op         = OP_SWR;
                state_next = ST_STEST;
            end
            ST_READ:
            begin
                op = OP_READ;
                priority if (st.run_empty)
                begin
                    state_next = ST_EMIT;
                end
                else if (st.small_lt3)
                begin
                    state_next = st.small_is2 ? ST_SEEKRD : ST_EMIT;
                end
                else
                begin
                    state_next = st.at_end ? ST_EMIT : ST_SEEKRD;
                end
            end
            ST_SEEKRD:
            begin
                op         = OP_SEEKRD;
                state_next = st.at_end ? ST_EMIT : ST_SEEKCHK;
            end
            ST_SEEKCHK:
            begin
                op         = OP_SEEKCHK;
                state_next = st.found ? ST_EMIT : ST_SEEKRD;
            end
            ST_EMIT:
            begin
                op = OP_EMIT;
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/psw30_dp.sv =====
// ----------------------------------------------------------------------------
// psw30_dp
// Datapath: sieve store, marking counters, read cursor and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prime_sieve_wheel30_unit_macros.svh"

module psw30_dp
    import psw30_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_op_t             op,
    input  wire logic [LIMIT_W-1:0] limit_in,
    input  wire logic               m_ready,
    output dp_status_t              st,
    output logic                    m_valid,
    output logic [PRIME_W-1:0]      m_prime,
    output logic                    m_last,
    output logic                    m_exh
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   row_count_reg;
    logic [ROW_AW-1:0]  fill_ptr_reg;
    logic [K_W-1:0]     k_reg;
    logic [NROW_W-1:0]  k30sq_reg;
    logic [2:0]         lane_p_reg;
    logic [NROW_W-1:0]  n_row_reg;
    logic [RES_W-1:0]   n_res_reg;
    logic [2:0]         li_reg;
    logic [CNT_W-1:0]   read_row_reg;
    logic [2:0]         read_lane_reg;
    logic [1:0]         small_reg;
    logic [PRIME_W-1:0] res_prime_reg;
    logic               res_exh_reg;
    logic               res_chk_reg;
    logic               out_valid_reg;
    logic [PRIME_W-1:0] out_prime_reg;
    logic               out_last_reg;
    logic               out_exh_reg;

    logic               ram_we;
    logic [ROW_AW-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic [ROW_AW-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    logic [LIMIT_W+18-1:0] div_prod;
    logic [NROW_W-1:0]     rows_calc;
    logic [CNT_W-1:0]      rows_sat;
    logic [3:0]            strike_lane;
    logic [7:0]            strike_mask;
    logic [9:0]            kr2;
    logic [NROW_W-1:0]     n_row_init;
    logic [6:0]            kg;
    logic [5:0]            res_sum;
    logic                  res_wrap;
    logic [RES_W-1:0]      n_res_adv;
    logic [NROW_W-1:0]     n_row_adv;
    logic [NROW_W-1:0]     k30sq_adv;
    logic [7:0]            seek_hits;
    logic [2:0]            seek_first;
    logic [PRIME_W-1:0]    cand_prime;
    logic [PRIME_W-1:0]    small_prime;
    logic                  out_free;

    psw30_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROWS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Row count from the limit: divide by 30 through the reciprocal, then saturate.
    assign div_prod  = limit_reg * 18'(DIV30_MUL);
    assign rows_calc = NROW_W'(div_prod[LIMIT_W+18-1:DIV30_SHIFT]) + NROW_W'(1);
    assign rows_sat  = (rows_calc > NROW_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                       : CNT_W'(rows_calc);

    // Strike arithmetic: start at p*p, step by p*gap kept as row and residue.
    assign kr2        = 10'(k_reg) * 10'(lane_res(lane_p_reg)) * 10'd2;
    assign n_row_init = k30sq_reg + NROW_W'(kr2) + NROW_W'(sq_div(lane_p_reg));
    assign kg         = 7'(k_reg) * 7'(lane_gap(li_reg));
    assign res_sum    = 6'(n_res_reg) + 6'(prod_mod(lane_p_reg, li_reg));
    assign res_wrap   = (res_sum >= 6'd30);
    assign n_res_adv  = res_wrap ? RES_W'(res_sum - 6'd30) : RES_W'(res_sum);
    assign n_row_adv  = n_row_reg + NROW_W'(kg) + NROW_W'(prod_div(lane_p_reg, li_reg))
                        + NROW_W'(res_wrap);
    assign k30sq_adv  = k30sq_reg + NROW_W'(10'(k_reg) * 10'd60) + NROW_W'(30);

    assign strike_lane = res_lane(n_res_reg);
    assign strike_mask = strike_lane[3] ? 8'h00 : (8'h01 << strike_lane[2:0]);

    // Seek: first set lane at or above the cursor lane.
    assign seek_hits = ram_rdata & (8'hFF << read_lane_reg);
    always_comb
    begin
        seek_first = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (seek_hits[i])
            begin
                seek_first = 3'(i);
            end
        end
    end

    // Candidate prime under the cursor and the three wheel primes.
    assign cand_prime = PRIME_W'(read_row_reg * 18'd30) + PRIME_W'(lane_res(read_lane_reg));
    always_comb
    begin
        unique case (small_reg)
            2'd0:    small_prime = PRIME_W'(2);
            2'd1:    small_prime = PRIME_W'(3);
            default: small_prime = PRIME_W'(5);
        endcase
    end

    // Store port selection.
    always_comb
    begin
        ram_we    = (op == OP_FILL) || (op == OP_SWR);
        ram_waddr = (op == OP_FILL) ? fill_ptr_reg : n_row_reg[ROW_AW-1:0];
        if (op == OP_FILL)
        begin
            ram_wdata = (fill_ptr_reg == '0) ? 8'hFE : 8'hFF;
        end
        else
        begin
            ram_wdata = ram_rdata & ~strike_mask;
        end
        priority if (op == OP_LRD)
        begin
            ram_raddr = ROW_AW'(k_reg);
        end
        else if (op == OP_STEST)
        begin
            ram_raddr = n_row_reg[ROW_AW-1:0];
        end
        else
        begin
            ram_raddr = read_row_reg[ROW_AW-1:0];
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    // Status towards the controller.
    always_comb
    begin
        st.fill_last  = (CNT_W'(fill_ptr_reg) + CNT_W'(1)) == row_count_reg;
        st.k_done     = k30sq_reg >= NROW_W'(row_count_reg);
        st.lane_bit   = ram_rdata[lane_p_reg];
        st.lane_last  = (lane_p_reg == 3'd7);
        st.strike_end = n_row_reg >= NROW_W'(row_count_reg);
        st.run_empty  = (row_count_reg == '0);
        st.small_lt3  = (small_reg != 2'd3);
        st.small_is2  = (small_reg == 2'd2);
        st.at_end     = (read_row_reg >= row_count_reg);
        st.found      = |seek_hits;
        st.out_free   = out_free;
    end

    // Payload registers: input limit and the pending result.
    always_ff @(posedge clk)
    begin
        if (op == OP_CAPTURE)
        begin
            limit_reg <= limit_in;
        end
        if (op == OP_READ)
        begin
            priority if (st.run_empty)
            begin
                res_prime_reg <= '0;
                res_exh_reg   <= 1'b1;
                res_chk_reg   <= 1'b0;
            end
            else if (st.small_lt3)
            begin
                res_prime_reg <= small_prime;
                res_exh_reg   <= 1'b0;
                res_chk_reg   <= st.small_is2;
            end
            else if (st.at_end)
            begin
                res_prime_reg <= '0;
                res_exh_reg   <= 1'b1;
                res_chk_reg   <= 1'b0;
            end
            else
            begin
                res_prime_reg <= cand_prime;
                res_exh_reg   <= 1'b0;
                res_chk_reg   <= 1'b1;
            end
        end
        if ((op == OP_EMIT) && out_free)
        begin
            out_prime_reg <= res_prime_reg;
            out_last_reg  <= res_chk_reg && st.at_end;
            out_exh_reg   <= res_exh_reg;
        end
    end

    // Control registers: run size, marking counters, cursor, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            fill_ptr_reg  <= '0;
            k_reg         <= '0;
            k30sq_reg     <= '0;
            lane_p_reg    <= '0;
            n_row_reg     <= '0;
            n_res_reg     <= '0;
            li_reg        <= '0;
            read_row_reg  <= '0;
            read_lane_reg <= '0;
            small_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (op)
                OP_DIV:
                begin
                    row_count_reg <= rows_sat;
                    fill_ptr_reg  <= '0;
                    k_reg         <= '0;
                    k30sq_reg     <= '0;
                    lane_p_reg    <= '0;
                    read_row_reg  <= '0;
                    read_lane_reg <= '0;
                    small_reg     <= '0;
                end
                OP_FILL:
                begin
                    fill_ptr_reg <= fill_ptr_reg + ROW_AW'(1);
                end
                OP_KCHK:
                begin
                    lane_p_reg <= '0;
                end
                OP_LCHK, OP_STEST:
                begin
                    if ((op == OP_LCHK) && st.lane_bit)
                    begin
                        n_row_reg <= n_row_init;
                        n_res_reg <= sq_mod(lane_p_reg);
                        li_reg    <= lane_p_reg;
                    end
                    else if ((op == OP_LCHK) || st.strike_end)
                    begin
                        // Next lane, and next row of primes after the top lane.
                        lane_p_reg <= lane_p_reg + 3'd1;
                        if (lane_p_reg == 3'd7)
                        begin
                            k_reg     <= k_reg + K_W'(1);
                            k30sq_reg <= k30sq_adv;
                        end
                    end
                end
                OP_SWR:
                begin
                    n_row_reg <= n_row_adv;
                    n_res_reg <= n_res_adv;
                    li_reg    <= li_reg + 3'd1;
                end
                OP_READ:
                begin
                    if (!st.run_empty && st.small_lt3)
                    begin
                        small_reg <= small_reg + 2'd1;
                    end
                    else if (!st.run_empty && !st.at_end)
                    begin
                        read_lane_reg <= read_lane_reg + 3'd1;
                        if (read_lane_reg == 3'd7)
                        begin
                            read_row_reg <= read_row_reg + CNT_W'(1);
                        end
                    end
                end
                OP_SEEKCHK:
                begin
                    if (st.found)
                    begin
                        read_lane_reg <= seek_first;
                    end
                    else
                    begin
                        read_lane_reg <= '0;
                        read_row_reg  <= read_row_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase

            // Output register: load when free, drop when taken.
            if ((op == OP_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_prime = out_prime_reg;
    assign m_last  = out_last_reg;
    assign m_exh   = out_exh_reg;

    // An exhausted result carries no prime and no last mark.
    `PSW30_ASSERT(a_exh_clean, out_valid_reg && out_exh_reg |-> out_prime_reg == '0 && !out_last_reg, "exhausted result with data")
    // The read cursor never runs past the end of the run.
    `PSW30_ASSERT_NEVER(a_cursor_bound, read_row_reg > row_count_reg, "cursor beyond run")
    // A strike only writes inside the run.
    `PSW30_ASSERT(a_strike_range, op == OP_SWR |-> n_row_reg < NROW_W'(row_count_reg), "strike outside run")
    // A result handed to a free output register is presented in the next cycle.
    `PSW30_ASSERT(a_emit_load, op == OP_EMIT && out_free |=> out_valid_reg, "result lost at output")

endmodule

`default_nettype wire

// ===== sv/prime_sieve_wheel30_unit.sv =====
// ----------------------------------------------------------------------------
// prime_sieve_wheel30_unit
// Wheel-30 sieve of Eratosthenes with a streaming reader of ascending primes.
//
//   Channel  Dir  Fields (low bit up)                   Transaction
//   s_*      in   tuser: opcode; tdata: limit[16:0]     0 = start run, 1 = read
//   m_*      out  tdata: prime[16:0]; tlast: is_last;   one per read, none per start
//                 tuser: exhausted
//
// A start captures the limit, divides it into rows and fills the store, then
// runs the marking pass: a row check per sieving row, a read and a check per
// examined lane, a closing test per set lane, a read and a write per struck multiple.
// A read takes the next small prime or candidate; its seek reads and checks each
// sieve row until it finds a set lane or runs off the end of the run.
// After reset no run exists and every read returns exhausted.
// A result waiting at the output does not block acceptance of the next
// transaction; only the following result waits for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sieve_wheel30_unit
    import psw30_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // limit[16:0], zero fill
    input  wire logic               s_tuser,   // opcode
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // prime[16:0], zero fill
    output logic                    m_tlast,   // is_last
    output logic                    m_tuser    // exhausted
);

    dp_op_t             op;
    dp_status_t         st;
    logic               idle;
    logic               s_accept;
    logic [PRIME_W-1:0] prime;

    // Input transaction handshake.
    assign s_tready = idle;
    assign s_accept = s_tvalid && idle;

    psw30_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_accept (s_accept),
        .in_read  (s_tuser),
        .st       (st),
        .op       (op),
        .idle     (idle)
    );

    psw30_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .limit_in (s_tdata[LIMIT_W-1:0]),
        .m_ready  (m_tready),
        .st       (st),
        .m_valid  (m_tvalid),
        .m_prime  (prime),
        .m_last   (m_tlast),
        .m_exh    (m_tuser)
    );

    // Result packing.
    assign m_tdata = {{(TDATA_W-PRIME_W){1'b0}}, prime};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for prime_sieve_wheel30_unit
// Drives start and read transactions and predicts every prime with its own
// wheel-30 sieve. Checks each result field by field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import psw30_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OPC_START = 1'b0;
    localparam logic OPC_READ  = 1'b1;
    localparam int   IDLE_LIMIT = 500000;
    localparam int   HOLD_CYCLES = 400;

    typedef struct {
        logic              opcode;
        logic [LIMIT_W-1:0] limit;
    } sieve_cmd_t;

    typedef struct {
        logic [PRIME_W-1:0] prime;
        logic               is_last;
        logic               exhausted;
    } prime_result_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    sieve_cmd_t    pending_cmds[$];
    prime_result_t expected_primes[$];
    int            err_count;
    int            idle_cycles;
    int            results_seen;

    // Shadow sieve and read cursor.
    logic [7:0]  shadow_rows [MAX_ROWS];
    int unsigned run_rows;
    int unsigned cur_row;
    int unsigned cur_lane;
    int unsigned smalls_done;

    prime_sieve_wheel30_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int unsigned wheel_residue(input int unsigned lane);
        case (lane)
            0: return 1;
            1: return 7;
            2: return 11;
            3: return 13;
            4: return 17;
            5: return 19;
            6: return 23;
            default: return 29;
        endcase
    endfunction

    function automatic int unsigned wheel_step(input int unsigned lane);
        case (lane)
            0, 6: return 6;
            2, 4, 7: return 2;
            default: return 4;
        endcase
    endfunction

    // Returns 8 for a residue that is not coprime to 30.
    function automatic int unsigned lane_of_residue(input int unsigned res);
        for (int unsigned l = 0; l < 8; l++)
            if (wheel_residue(l) == res)
                return l;
        return 8;
    endfunction

    // Moves the cursor to the next surviving candidate, or past the last row.
    function automatic void seek_candidate();
        while (cur_row < run_rows) begin
            while (cur_lane < 8) begin
                if (shadow_rows[cur_row][cur_lane])
                    return;
                cur_lane++;
            end
            cur_lane = 0;
            cur_row++;
        end
        cur_lane = 0;
    endfunction

    function automatic void sieve_run(input logic [LIMIT_W-1:0] limit);
        longint unsigned span;
        longint unsigned p;
        longint unsigned q;
        longint unsigned n;
        int unsigned     li;
        int unsigned     ln;
        run_rows = limit / 30 + 1;
        if (run_rows > MAX_ROWS)
            run_rows = MAX_ROWS;
        for (int unsigned r = 0; r < run_rows; r++)
            shadow_rows[r] = 8'hFF;
        shadow_rows[0][0] = 1'b0;
        span = 30 * longint'(run_rows);
        for (int unsigned k = 0; 30 * k * k < run_rows; k++) begin
            for (int unsigned i = 0; i < 8; i++) begin
                if (shadow_rows[k][i]) begin
                    p  = 30 * k + wheel_residue(i);
                    q  = p;
                    li = i;
                    n  = p * q;
                    while (n < span) begin
                        ln = lane_of_residue(int'(n % 30));
                        if (ln < 8)
                            shadow_rows[n / 30][ln] = 1'b0;
                        q  = q + wheel_step(li);
                        li = (li + 1) % 8;
                        n  = p * q;
                    end
                end
            end
        end
        cur_row     = 0;
        cur_lane    = 0;
        smalls_done = 0;
    endfunction

    // Applies one accepted command and queues the result that it causes.
    function automatic void predict_command(input logic opcode, input logic [LIMIT_W-1:0] limit);
        prime_result_t res;
        int unsigned   value;
        if (opcode == OPC_START) begin
            sieve_run(limit);
            return;
        end
        res.prime     = '0;
        res.is_last   = 1'b0;
        res.exhausted = 1'b0;
        if (run_rows == 0) begin
            res.exhausted = 1'b1;
        end else if (smalls_done < 3) begin
            res.prime = (smalls_done == 0) ? 17'd2 : (smalls_done == 1) ? 17'd3 : 17'd5;
            smalls_done++;
            if (smalls_done == 3) begin
                seek_candidate();
                res.is_last = (cur_row >= run_rows);
            end
        end else begin
            seek_candidate();
            if (cur_row >= run_rows) begin
                res.exhausted = 1'b1;
            end else begin
                value     = 30 * cur_row + wheel_residue(cur_lane);
                res.prime = value[PRIME_W-1:0];
                cur_lane++;
                seek_candidate();
                res.is_last = (cur_row >= run_rows);
            end
        end
        expected_primes = {expected_primes, res};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic push_cmd(input logic opcode, input int unsigned limit);
        sieve_cmd_t c;
        c.opcode = opcode;
        c.limit  = limit[LIMIT_W-1:0];
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic push_reads(input int count);
        for (int i = 0; i < count; i++)
            push_cmd(OPC_READ, $urandom_range(0, 131071));
    endtask

    // Stimulus: a directed part, then random runs of start plus reads.
    initial
    begin
        int          total;
        int unsigned lim;
        int          reads;
        push_cmd(OPC_READ, 0);          // read before any run exists
        push_cmd(OPC_START, 0);         // single row: 2 .. 29
        push_reads(12);                 // runs past the last prime
        push_cmd(OPC_START, 122879);    // full store
        push_reads(4);
        push_cmd(OPC_START, 131071);    // limit saturates
        push_reads(3);
        push_cmd(OPC_START, 59);        // restart in the middle of a run
        push_reads(3);
        total = pending_cmds.size();
        while (total < 2000) begin
            if ($urandom_range(0, 6) == 0) begin
                // Noise: stray reads or a short restart.
                if ($urandom_range(0, 1) == 0)
                    push_cmd(OPC_START, $urandom_range(0, 400));
                push_reads($urandom_range(1, 5));
            end else begin
                if ($urandom_range(0, 60) == 0)
                    lim = $urandom_range(0, 131071);
                else if ($urandom_range(0, 3) == 0)
                    lim = $urandom_range(0, 60);
                else
                    lim = $urandom_range(0, 3000);
                push_cmd(OPC_START, lim);
                reads = (lim < 300) ? $urandom_range(1, 70) : $urandom_range(5, 150);
                push_reads(reads);
            end
            total = pending_cmds.size();
        end
    end

    // Driver: offers queued commands with a random gap before each one.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        static int gap_left = 0;
        static bit burst    = 1'b0;
        sieve_cmd_t c;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_command(s_tuser, s_tdata[LIMIT_W-1:0]);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c        = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= c.opcode;
                    s_tdata  <= {{(TDATA_W-LIMIT_W){1'b0}}, c.limit};
                    if ($urandom_range(0, 40) == 0)
                        burst = ~burst;
                    gap_left = burst ? 0 : $urandom_range(0, 13);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, one long hold-off, and result checks.
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        static int stall_left = 0;
        static int hold_left  = 0;
        static bit hold_done  = 1'b0;
        static bit burst      = 1'b0;
        prime_result_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_primes.size() == 0) begin
                    report_mismatch("unexpected result, prime", m_tdata, 0);
                end else begin
                    want = expected_primes.pop_front();
                    if (m_tdata !== {{(TDATA_W-PRIME_W){1'b0}}, want.prime})
                        report_mismatch("prime", m_tdata, want.prime);
                    if (m_tlast !== want.is_last)
                        report_mismatch("is_last", m_tlast, want.is_last);
                    if (m_tuser !== want.exhausted)
                        report_mismatch("exhausted", m_tuser, want.exhausted);
                end
                if ($urandom_range(0, 40) == 0)
                    burst = ~burst;
                stall_left = burst ? 0 : $urandom_range(0, 13);
            end
            // Hold off once mid-run so that the block fills up and stalls its input.
            if (!hold_done && results_seen >= 300) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which no transaction is accepted.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // End of run.
    initial
    begin
        err_count    = 0;
        idle_cycles  = 0;
        results_seen = 0;
        run_rows     = 0;
        cur_row      = 0;
        cur_lane     = 0;
        smalls_done  = 0;
        @(posedge rst_n);
        repeat (2) @(posedge clk);
        while (pending_cmds.size() > 0 || s_tvalid || expected_primes.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== prime_sieve_wheel30_unit.f =====
+incdir+sv
sv/psw30_pkg.sv
sv/psw30_ram.sv
sv/psw30_ctrl.sv
sv/psw30_dp.sv
sv/prime_sieve_wheel30_unit.sv
tb/testbench.sv
